// ===== rtl/core/edt_pkg.sv =====
// ----------------------------------------------------------------------------
// edt_pkg: shared types and constants of the encoder detent tracker
// Holds the request structs of both channels, register indexes, detent
// mode codes and the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package edt_pkg;

  // Request fields of one input item
  typedef struct packed {
    logic               opcode;
    logic        [15:0] raw_angle;
    logic signed [31:0] new_position;
  } edt_in_t;

  // Request fields of one result item
  typedef struct packed {
    logic signed [31:0] position;
    logic signed [31:0] detent_position;
    logic signed [15:0] detent_offset;
    logic               in_detent;
    logic               entered_detent;
  } edt_out_t;

  // Opcodes
  localparam logic OP_ANGLE   = 1'b0;
  localparam logic OP_SET_POS = 1'b1;

  // Configuration register indexes
  localparam int unsigned CFG_INDEX_WIDTH = 2;
  localparam int unsigned CFG_DATA_WIDTH  = 16;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_IDX_MODE    = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_IDX_SPACING = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_IDX_FRAC    = 2'd2;

  // Detent modes
  localparam logic [2:0] MODE_NONE   = 3'd0;
  localparam logic [2:0] MODE_LIGHT  = 3'd1;
  localparam logic [2:0] MODE_MEDIUM = 3'd2;
  localparam logic [2:0] MODE_HEAVY  = 3'd3;
  localparam logic [2:0] MODE_CUSTOM = 3'd4;

  // Fixed spacings in position counts
  localparam logic [15:0] SPACING_LIGHT  = 16'd683;
  localparam logic [15:0] SPACING_MEDIUM = 16'd1365;
  localparam logic [15:0] SPACING_HEAVY  = 16'd2731;

  // Register reset values
  localparam logic [2:0]  MODE_RESET    = MODE_MEDIUM;
  localparam logic [15:0] SPACING_RESET = 16'd1365;
  localparam logic [7:0]  FRAC_RESET    = 8'd26;

  // Controller to datapath commands
  typedef struct packed {
    logic accept_item;  // apply the accepted request to the position
    logic cfg_write;    // write the addressed register
    logic start;        // latch spacing, zone and start the remainder unit
    logic fix_mod;      // turn the magnitude remainder into a floor modulo
    logic fix_wrap;     // add half a spacing and wrap
    logic apply;        // update dead-zone flag and held detent
    logic load_out;     // load the result register
  } edt_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic rem_done;     // remainder unit finished
    logic out_busy;     // result register full and stalled
  } edt_status_t;

endpackage

// ===== rtl/core/edt_rem.sv =====
// ----------------------------------------------------------------------------
// edt_rem: iterative remainder unit
// Restoring division of an unsigned dividend by a 16-bit divisor, one
// dividend bit per cycle; only the remainder is kept.
// ----------------------------------------------------------------------------
module edt_rem #(
  parameter int unsigned DIVIDEND_WIDTH = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [DIVIDEND_WIDTH-1:0] dividend_i,
  input  logic [15:0]               divisor_i,
  output logic                      done_o,
  output logic [15:0]               rem_o
);

  localparam int unsigned CntWidth = $clog2(DIVIDEND_WIDTH + 1);

  logic [CntWidth-1:0]       cnt_q, cnt_d;
  logic [DIVIDEND_WIDTH-1:0] shift_q, shift_d;
  logic [15:0]               rem_q, rem_d;
  logic [15:0]               div_q, div_d;
  logic [16:0]               trial;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    trial   = {rem_q, shift_q[DIVIDEND_WIDTH-1]};
    cnt_d   = cnt_q;
    shift_d = shift_q;
    rem_d   = rem_q;
    div_d   = div_q;
    if (start_i) begin
      cnt_d   = CntWidth'(DIVIDEND_WIDTH);
      shift_d = dividend_i;
      rem_d   = '0;
      div_d   = divisor_i;
    end else if (cnt_q != '0) begin
      cnt_d   = cnt_q - CntWidth'(1);
      shift_d = {shift_q[DIVIDEND_WIDTH-2:0], 1'b0};
      if (trial >= {1'b0, div_q}) begin
        rem_d = 16'(trial - {1'b0, div_q});
      end else begin
        rem_d = trial[15:0];
      end
    end
  end

  // Hold the step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Advance the working registers
  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
    rem_q   <= rem_d;
    div_q   <= div_d;
  end

  assign done_o = (cnt_q == '0);
  assign rem_o  = rem_q;

endmodule

// ===== rtl/core/edt_datapath.sv =====
// ----------------------------------------------------------------------------
// edt_datapath: position unwrap and detent evaluation
// Holds the configuration registers, the unwrapped position, the detent
// state and the result register; runs the steps the controller commands.
// ----------------------------------------------------------------------------
module edt_datapath #(
  parameter int unsigned POSITION_WIDTH = 32,
  parameter int unsigned ANGLE_WIDTH    = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  edt_pkg::edt_cmd_t                      cmd_i,
  output edt_pkg::edt_status_t                   status_o,
  input  edt_pkg::edt_in_t                       in_data_i,
  input  logic [edt_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index_i,
  input  logic [edt_pkg::CFG_DATA_WIDTH-1:0]     cfg_data_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output edt_pkg::edt_out_t                      out_data_o
);

  import edt_pkg::*;

  localparam int unsigned PW = POSITION_WIDTH;
  localparam int unsigned AW = ANGLE_WIDTH;

  // Configuration registers
  logic [2:0]  mode_q;
  logic [15:0] spacing_q;
  logic [7:0]  frac_q;

  // Tracking state
  logic [AW-1:0] last_angle_q;
  logic          primed_q;
  logic [PW-1:0] pos_q, pos_d;
  logic [PW-1:0] held_q, held_d;
  logic          inside_q, inside_d;
  logic          entered_q, entered_d;
  logic signed [16:0] off_q, off_d;

  // Evaluation registers
  logic [15:0] eval_s_q, eval_h_q, zone_q, m_q, t_q;
  logic        neg_q;

  // Result register
  logic     out_valid_q;
  edt_out_t out_q;

  logic [15:0]        spacing;
  logic [23:0]        zone_prod;
  logic [AW-1:0]      angle, angle_diff;
  logic [PW-1:0]      pos_abs;
  logic [15:0]        rem;
  logic               rem_done;
  logic [16:0]        wrap_sum;
  logic signed [16:0] off_new;
  logic [15:0]        mag;
  logic               in_new;
  logic signed [PW-1:0] off_ext;

  // Select the spacing of the current mode; zero custom spacing counts as one
  always_comb begin
    case (mode_q)
      MODE_LIGHT:  spacing = SPACING_LIGHT;
      MODE_MEDIUM: spacing = SPACING_MEDIUM;
      MODE_HEAVY:  spacing = SPACING_HEAVY;
      default:     spacing = (spacing_q == '0) ? 16'd1 : spacing_q;
    endcase
  end

  assign zone_prod = 24'(spacing) * 24'(frac_q);

  // Unwrap the angle difference into the position
  assign angle      = in_data_i.raw_angle[AW-1:0];
  assign angle_diff = angle - last_angle_q;

  always_comb begin
    pos_d = pos_q;
    if (cmd_i.accept_item) begin
      if (in_data_i.opcode == OP_SET_POS) begin
        pos_d = PW'(in_data_i.new_position);
      end else if (primed_q) begin
        pos_d = pos_q + PW'($signed(angle_diff));
      end
    end
  end

  // Magnitude of the position for the remainder unit
  assign pos_abs = pos_q[PW-1] ? (~pos_q + PW'(1)) : pos_q;

  edt_rem #(
    .DIVIDEND_WIDTH(PW)
  ) u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.start),
    .dividend_i (pos_abs),
    .divisor_i  (spacing),
    .done_o     (rem_done),
    .rem_o      (rem)
  );

  // Offset from the nearest detent and dead-zone test
  assign wrap_sum = {1'b0, m_q} + {1'b0, eval_h_q};
  assign off_new  = $signed({1'b0, t_q}) - $signed({1'b0, eval_h_q});
  assign mag      = (t_q >= eval_h_q) ? (t_q - eval_h_q) : (eval_h_q - t_q);
  assign in_new   = (mag <= zone_q);
  assign off_ext  = PW'(off_new);

  always_comb begin
    inside_d  = inside_q;
    held_d    = held_q;
    off_d     = off_q;
    entered_d = entered_q;
    if (cmd_i.apply) begin
      if (mode_q == MODE_NONE) begin
        inside_d  = 1'b0;
        held_d    = pos_q;
        off_d     = '0;
        entered_d = 1'b0;
      end else begin
        inside_d  = in_new;
        off_d     = off_new;
        entered_d = in_new && !inside_q;
        if (in_new) begin
          held_d = pos_q - off_ext;
        end
      end
    end
  end

  // Hold configuration and tracking state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_RESET;
      spacing_q    <= SPACING_RESET;
      frac_q       <= FRAC_RESET;
      last_angle_q <= '0;
      primed_q     <= 1'b0;
      pos_q        <= '0;
      held_q       <= '0;
      inside_q     <= 1'b1;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.cfg_write) begin
        case (cfg_index_i)
          CFG_IDX_MODE:    mode_q    <= cfg_data_i[2:0];
          CFG_IDX_SPACING: spacing_q <= cfg_data_i[15:0];
          CFG_IDX_FRAC:    frac_q    <= cfg_data_i[7:0];
          default:         ;
        endcase
      end
      if (cmd_i.accept_item && in_data_i.opcode == OP_ANGLE) begin
        last_angle_q <= angle;
        primed_q     <= 1'b1;
      end
      pos_q    <= pos_d;
      held_q   <= held_d;
      inside_q <= inside_d;
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Advance the evaluation steps
  always_ff @(posedge clk_i) begin
    off_q     <= off_d;
    entered_q <= entered_d;
    if (cmd_i.start) begin
      eval_s_q <= spacing;
      eval_h_q <= {1'b0, spacing[15:1]};
      zone_q   <= zone_prod[23:8];
      neg_q    <= pos_q[PW-1];
    end
    if (cmd_i.fix_mod) begin
      m_q <= (neg_q && rem != '0) ? (eval_s_q - rem) : rem;
    end
    if (cmd_i.fix_wrap) begin
      t_q <= (wrap_sum >= {1'b0, eval_s_q}) ? 16'(wrap_sum - {1'b0, eval_s_q})
                                             : wrap_sum[15:0];
    end
    if (cmd_i.load_out) begin
      out_q.position        <= 32'($unsigned(pos_q));
      out_q.detent_position <= 32'($unsigned(held_q));
      out_q.detent_offset   <= off_q[15:0];
      out_q.in_detent       <= (mode_q != MODE_NONE) && inside_q;
      out_q.entered_detent  <= entered_q;
    end
  end

  assign status_o.rem_done = rem_done;
  assign status_o.out_busy = out_valid_q && out_stall_i;
  assign out_valid_o       = out_valid_q;
  assign out_data_o        = out_q;

endmodule

// ===== rtl/core/edt_ctrl.sv =====
// ----------------------------------------------------------------------------
// edt_ctrl: sequencer of the encoder detent tracker
// Takes requests and register writes while idle, then steps the datapath
// through remainder, wrap, apply and, for requests, result load.
// ----------------------------------------------------------------------------
module edt_ctrl (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [edt_pkg::CFG_INDEX_WIDTH-1:0] cfg_index_i,
  output edt_pkg::edt_cmd_t                   cmd_o,
  input  edt_pkg::edt_status_t                status_i
);

  import edt_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_START = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_MOD   = 3'd3;
  localparam logic [2:0] ST_WRAP  = 3'd4;
  localparam logic [2:0] ST_APPLY = 3'd5;
  localparam logic [2:0] ST_OUT   = 3'd6;

  logic [2:0] state_q, state_d;
  logic       report_q, report_d;
  logic       idle;

  assign idle        = (state_q == ST_IDLE);
  assign cfg_ready_o = idle;
  assign in_stall_o  = !idle || cfg_valid_i;

  // Sequence one evaluation
  always_comb begin
    state_d  = state_q;
    report_d = report_q;
    cmd_o    = '0;
    case (state_q)
      ST_IDLE: begin
        if (cfg_valid_i) begin
          cmd_o.cfg_write = 1'b1;
          if (cfg_index_i inside {CFG_IDX_MODE, CFG_IDX_SPACING, CFG_IDX_FRAC}) begin
            report_d = 1'b0;
            state_d  = ST_START;
          end
        end else if (in_valid_i) begin
          cmd_o.accept_item = 1'b1;
          report_d          = 1'b1;
          state_d           = ST_START;
        end
      end
      ST_START: begin
        cmd_o.start = 1'b1;
        state_d     = ST_DIV;
      end
      ST_DIV: begin
        if (status_i.rem_done) begin
          state_d = ST_MOD;
        end
      end
      ST_MOD: begin
        cmd_o.fix_mod = 1'b1;
        state_d       = ST_WRAP;
      end
      ST_WRAP: begin
        cmd_o.fix_wrap = 1'b1;
        state_d        = ST_APPLY;
      end
      ST_APPLY: begin
        cmd_o.apply = 1'b1;
        state_d     = report_q ? ST_OUT : ST_IDLE;
      end
      ST_OUT: begin
        if (!status_i.out_busy) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      report_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      report_q <= report_d;
    end
  end

endmodule

// ===== rtl/core/encoder_detent_tracker.sv =====
// ----------------------------------------------------------------------------
// encoder_detent_tracker: rotary encoder unwrap and detent snap
// Unwraps absolute encoder angles into a position and snaps it to a
// detent grid, reporting held detent, offset and dead-zone events.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake           payload
//   in       input      in_valid / stall    edt_in_t  (opcode, angle, position)
//   out      output     out_valid / stall   edt_out_t (position, detent, flags)
//   cfg      input      cfg_valid / ready   2-bit index, 16-bit data
//
// Each request runs the remainder unit, one dividend bit per cycle, then the
// modulo fix, wrap, apply and result load; a register write to a known
// index re-runs the same evaluation without loading a result.
// Reset is asynchronous, active low, and restores the register defaults.
// A stalled result is held in the output register; a new request may be
// taken meanwhile and waits at the final step until that register frees.
//
module encoder_detent_tracker #(
  parameter int unsigned POSITION_WIDTH = 32,
  parameter int unsigned ANGLE_WIDTH    = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  edt_pkg::edt_in_t                    in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output edt_pkg::edt_out_t                   out_data_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [edt_pkg::CFG_INDEX_WIDTH-1:0] cfg_index_i,
  input  logic [edt_pkg::CFG_DATA_WIDTH-1:0]  cfg_data_i
);

  import edt_pkg::*;

  edt_cmd_t    cmd;
  edt_status_t status;

  // Sequencer
  edt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  // Datapath
  edt_datapath #(
    .POSITION_WIDTH(POSITION_WIDTH),
    .ANGLE_WIDTH   (ANGLE_WIDTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_data_i   (in_data_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== rtl/core/edt_checker.sv =====
// ----------------------------------------------------------------------------
// edt_checker: port-level checks of the encoder detent tracker
// Watches the top-level ports over time; attached by a bind statement.
// ----------------------------------------------------------------------------
module edt_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input edt_pkg::edt_out_t out_data_o,
  input logic              cfg_valid_i,
  input logic              cfg_ready_o
);

  import edt_pkg::*;

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // An entry event only comes with the dead-zone flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.entered_detent |-> out_data_o.in_detent)
    else $error("entry event without dead-zone flag");

  // Inside the dead zone the held detent is the position less the offset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.in_detent |->
      out_data_o.detent_position[16:0] ==
        out_data_o.position[16:0] - 17'(out_data_o.detent_offset))
    else $error("held detent does not match position and offset");

  // A request and a register write are never taken together
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_valid_i && !in_stall_o && cfg_valid_i && cfg_ready_o))
    else $error("request and register write taken in one cycle");

  // After a request is taken the input stalls while it is evaluated
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o && !cfg_ready_o)
    else $error("input not stalled during evaluation");

endmodule

bind encoder_detent_tracker edt_checker u_edt_checker (.*);

// ===== tb/encoder_detent_tracker_tb.sv =====
// ----------------------------------------------------------------------------
// encoder_detent_tracker_tb: self-checking bench of the encoder detent tracker
// Drives angle samples and set-position requests against a behavioural
// tracker that unwraps, accumulates and snaps to the detent grid, and checks
// every result in order. Register settings are changed only while idle.
// ----------------------------------------------------------------------------
module encoder_detent_tracker_tb;
  import edt_pkg::*;

  // Unused register index and the spare mode codes that fall back to custom
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_IDX_UNUSED = 2'd3;
  localparam logic [2:0] MODE_SPARE_LO  = 3'd5;
  localparam logic [2:0] MODE_SPARE_MID = 3'd6;
  localparam logic [2:0] MODE_SPARE_HI  = 3'd7;

  // Cycles to let an evaluation drain, and the run limit
  localparam int unsigned SETTLE_CYCLES = 48;
  localparam int unsigned CYCLE_LIMIT   = 600000;
  localparam int unsigned RANDOM_BLOCKS = 8;
  localparam int unsigned BLOCK_ITEMS   = 75;

  logic                       clk_i       = 1'b0;
  logic                       rst_ni      = 1'b0;
  logic                       in_valid_i  = 1'b0;
  logic                       in_stall_o;
  edt_in_t                    in_data_i   = '0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  edt_out_t                   out_data_o;
  logic                       cfg_valid_i = 1'b0;
  logic                       cfg_ready_o;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index_i = '0;
  logic [CFG_DATA_WIDTH-1:0]  cfg_data_i  = '0;

  // Tracker state of the predictor
  logic [2:0]         mode_q;
  logic [15:0]        spacing_q;
  logic [7:0]         frac_q;
  logic [15:0]        angle_q;
  logic               primed_q;
  logic signed [31:0] pos_q;
  logic signed [31:0] held_q;
  logic               inside_q;

  edt_out_t    expected_results[$];
  edt_out_t    result_want;
  logic [15:0] drive_angle;
  int unsigned gap_pct;
  int unsigned stall_pct;
  int unsigned fault_count;
  int unsigned requests_sent;
  int unsigned results_seen;
  int unsigned register_writes;
  int unsigned cycle_count;

  encoder_detent_tracker u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // Clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_results.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // Restore the tracker and register defaults
  function automatic void reset_tracker();
    mode_q    = MODE_RESET;
    spacing_q = SPACING_RESET;
    frac_q    = FRAC_RESET;
    angle_q   = '0;
    primed_q  = 1'b0;
    pos_q     = '0;
    held_q    = '0;
    inside_q  = 1'b1;
  endfunction

  // Snap the position to the nearest detent; return a rising dead-zone entry
  function automatic logic snap_to_detent(output logic signed [15:0] offset);
    longint s, h, v, m, t, d, zone;
    logic   was;
    if (mode_q == MODE_NONE) begin
      inside_q = 1'b0;
      held_q   = pos_q;
      offset   = '0;
      return 1'b0;
    end
    case (mode_q)
      MODE_LIGHT:  s = SPACING_LIGHT;
      MODE_MEDIUM: s = SPACING_MEDIUM;
      MODE_HEAVY:  s = SPACING_HEAVY;
      default:     s = (spacing_q == 16'd0) ? 1 : longint'(spacing_q);
    endcase
    h = s / 2;
    v = pos_q;
    // floor modulo, then round half up around the detent
    m = v % s;
    if (m < 0) m = m + s;
    t = (m + h) % s;
    d = t - h;
    zone = (s * longint'(frac_q)) >>> 8;
    was = inside_q;
    inside_q = ((d < 0) ? -d : d) <= zone;
    if (inside_q) held_q = pos_q - d[31:0];
    offset = d[15:0];
    return inside_q && !was;
  endfunction

  // Predict the result of one accepted request
  function automatic edt_out_t track_step(edt_in_t req);
    edt_out_t           res;
    logic signed [15:0] off;
    logic               ent;
    logic [15:0]        delta;
    if (req.opcode == OP_SET_POS) begin
      pos_q = req.new_position;
    end else begin
      if (primed_q) begin
        delta = req.raw_angle - angle_q;
        pos_q = pos_q + {{16{delta[15]}}, delta};
      end
      angle_q  = req.raw_angle;
      primed_q = 1'b1;
    end
    ent = snap_to_detent(off);
    res.position        = pos_q;
    res.detent_position = held_q;
    res.detent_offset   = off;
    res.in_detent       = (mode_q != MODE_NONE) && inside_q;
    res.entered_detent  = ent;
    return res;
  endfunction

  // Apply a register write; known indexes re-run the snap without a result
  function automatic void apply_register(logic [CFG_INDEX_WIDTH-1:0] idx,
                                         logic [CFG_DATA_WIDTH-1:0] value);
    logic signed [15:0] dropped_off;
    logic               dropped_ent;
    case (idx)
      CFG_IDX_MODE:    mode_q    = value[2:0];
      CFG_IDX_SPACING: spacing_q = value;
      CFG_IDX_FRAC:    frac_q    = value[7:0];
      default:         return;
    endcase
    dropped_ent = snap_to_detent(dropped_off);
  endfunction

  // Send one request, at times with a random idle gap ahead of it
  task automatic send_request(input logic op, input logic [15:0] angle,
                              input logic [31:0] pos);
    edt_in_t     req;
    int unsigned gap;
    req.opcode       = op;
    req.raw_angle    = angle;
    req.new_position = pos;
    gap = 0;
    if ($urandom_range(99) < gap_pct) gap = $urandom_range(1, 60);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (in_stall_o);
    expected_results.push_back(track_step(req));
    if (op == OP_ANGLE) drive_angle = angle;
    requests_sent++;
  endtask

  // Drop valid, drain every pending result and let the block settle
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write one register, then hold off while the block re-evaluates
  task automatic write_register(input logic [CFG_INDEX_WIDTH-1:0] idx,
                                input logic [CFG_DATA_WIDTH-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    apply_register(idx, value);
    register_writes++;
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Check each accepted result against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        fault_count++;
        if (fault_count <= 10)
          $display("unexpected result: pos %h det %h off %h in %b ent %b",
                   out_data_o.position, out_data_o.detent_position,
                   out_data_o.detent_offset, out_data_o.in_detent,
                   out_data_o.entered_detent);
      end else begin
        result_want = expected_results.pop_front();
        if (out_data_o.position !== result_want.position ||
            out_data_o.detent_position !== result_want.detent_position ||
            out_data_o.detent_offset !== result_want.detent_offset ||
            out_data_o.in_detent !== result_want.in_detent ||
            out_data_o.entered_detent !== result_want.entered_detent) begin
          fault_count++;
          if (fault_count <= 10) begin
            $display("result %0d expected: pos %h det %h off %h in %b ent %b",
                     results_seen, result_want.position, result_want.detent_position,
                     result_want.detent_offset, result_want.in_detent,
                     result_want.entered_detent);
            $display("result %0d actual:   pos %h det %h off %h in %b ent %b",
                     results_seen, out_data_o.position, out_data_o.detent_position,
                     out_data_o.detent_offset, out_data_o.in_detent,
                     out_data_o.entered_detent);
          end
        end
      end
    end
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // Unwrap across the half-turn limits, unprimed start and 32-bit wrap
  task automatic test_unwrap_and_wrap();
    send_request(OP_SET_POS, 16'h1234, 32'd1000);
    send_request(OP_ANGLE, 16'hFFFF, 32'hFFFF_FFFF);
    send_request(OP_ANGLE, 16'h0000, 32'h0000_0000);
    send_request(OP_ANGLE, 16'h8000, 32'h5555_5555);
    send_request(OP_ANGLE, 16'hFFFF, 32'hAAAA_AAAA);
    send_request(OP_SET_POS, 16'h0000, 32'h7FFF_FFFF);
    send_request(OP_ANGLE, 16'h0000, 32'h0000_0000);
    send_request(OP_ANGLE, 16'hFFFF, 32'h0000_0000);
    send_request(OP_SET_POS, 16'hFFFF, 32'h8000_0000);
    send_request(OP_ANGLE, 16'h7FFF, 32'h0000_0000);
  endtask

  // Floor rounding on both sides of the half spacing, negatives included
  task automatic test_floor_rounding();
    send_request(OP_SET_POS, 16'h0000, -32'sd1);
    send_request(OP_SET_POS, 16'h0000, 32'sd682);
    send_request(OP_SET_POS, 16'h0000, 32'sd683);
    send_request(OP_SET_POS, 16'h0000, -32'sd682);
    send_request(OP_SET_POS, 16'h0000, -32'sd683);
    send_request(OP_SET_POS, 16'h0000, -32'sd3413);
    send_request(OP_SET_POS, 16'h0000, 32'sd0);
  endtask

  // Ignored index, masked data, mode none, spare modes and zero spacing
  task automatic test_register_writes();
    wait_idle();
    write_register(CFG_IDX_UNUSED, 16'hFFFF);
    send_request(OP_ANGLE, 16'h0100, 32'h0000_0000);
    wait_idle();
    write_register(CFG_IDX_MODE, 16'hFFF8 | 16'(MODE_NONE));
    send_request(OP_ANGLE, 16'h0200, 32'h0000_0000);
    wait_idle();
    write_register(CFG_IDX_MODE, 16'h0000 | 16'(MODE_SPARE_HI));
    write_register(CFG_IDX_SPACING, 16'h0000);
    write_register(CFG_IDX_FRAC, 16'hFFFF);
    send_request(OP_SET_POS, 16'h0000, 32'sd12345);
    wait_idle();
    write_register(CFG_IDX_MODE, 16'hABC0 | 16'(MODE_SPARE_MID));
    write_register(CFG_IDX_SPACING, 16'hFFFF);
    send_request(OP_SET_POS, 16'h0000, 32'sd40000);
    send_request(OP_SET_POS, 16'h0000, -32'sd40000);
  endtask

  // Random encoder motion across register settings and idling profiles
  task automatic test_random_motion();
    int unsigned blk;
    int unsigned n;
    int unsigned kind;
    int          step;
    logic [2:0]  m;
    logic [15:0] sp;
    logic [7:0]  fr;
    logic [31:0] pos;
    for (blk = 0; blk < RANDOM_BLOCKS; blk++) begin
      wait_idle();
      case (blk / 2)
        0:       begin gap_pct = 0;  stall_pct = 0;  end
        1:       begin gap_pct = 66; stall_pct = 0;  end
        2:       begin gap_pct = 0;  stall_pct = 66; end
        default: begin gap_pct = 30; stall_pct = 30; end
      endcase
      case (blk)
        0:       begin m = MODE_LIGHT;     sp = 16'd1365;  fr = 8'd255; end
        1:       begin m = MODE_MEDIUM;    sp = 16'd1365;  fr = 8'd26;  end
        2:       begin m = MODE_CUSTOM;    sp = 16'hFFFF;  fr = 8'd0;   end
        3:       begin m = MODE_HEAVY;     sp = 16'd1;     fr = 8'd128; end
        4:       begin m = MODE_NONE;      sp = 16'd300;   fr = 8'd200; end
        5:       begin m = MODE_SPARE_HI;  sp = 16'd2;     fr = 8'd255; end
        6:       begin m = MODE_CUSTOM;    sp = 16'd0;     fr = 8'd64;  end
        default: begin m = MODE_SPARE_LO;  sp = 16'd1000;  fr = 8'd90;  end
      endcase
      write_register(CFG_IDX_MODE, {13'($urandom), m});
      write_register(CFG_IDX_SPACING, sp);
      write_register(CFG_IDX_FRAC, {8'($urandom), fr});
      for (n = 0; n < BLOCK_ITEMS; n++) begin
        kind = $urandom_range(99);
        if (kind < 60) begin
          step = int'($urandom_range(0, 800)) - 400;
          send_request(OP_ANGLE, drive_angle + 16'(step), $urandom);
        end else if (kind < 80) begin
          step = int'($urandom_range(0, 16000)) - 8000;
          send_request(OP_ANGLE, drive_angle + 16'(step), $urandom);
        end else if (kind < 90) begin
          send_request(OP_ANGLE, 16'($urandom), $urandom);
        end else if (kind < 97) begin
          if ($urandom_range(1) == 0) pos = $urandom;
          else pos = 32'(int'($urandom_range(0, 10000)) - 5000);
          send_request(OP_SET_POS, 16'($urandom), pos);
        end else begin
          case ($urandom_range(3))
            0:       pos = 32'h7FFF_FFFF;
            1:       pos = 32'h8000_0000;
            2:       pos = 32'h0000_0000;
            default: pos = 32'hFFFF_FFFF;
          endcase
          send_request(OP_SET_POS, 16'($urandom), pos);
        end
      end
    end
  endtask

  // Sequence the tests and report
  initial begin
    reset_tracker();
    drive_angle     = '0;
    gap_pct         = 0;
    stall_pct       = 0;
    fault_count     = 0;
    requests_sent   = 0;
    results_seen    = 0;
    register_writes = 0;
    cycle_count     = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_unwrap_and_wrap();
    test_floor_rounding();
    test_register_writes();
    test_random_motion();

    // Drain and let any stray result show up
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Sent %0d requests, checked %0d results, %0d register writes",
             requests_sent, results_seen, register_writes);
    $display("Covered all detent modes, spare codes, zero spacing and idle profiles");
    if (fault_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d faulty results", fault_count);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
